// File: design/pfsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsb_pkg
// Shared types and constants for the polar free-space bin profile.
// ----------------------------------------------------------------------------
package pfsb_pkg;

    localparam int BIN_W        = 9;
    localparam int DIST_W       = 16;
    localparam int CLASS_W      = 3;
    localparam int NUM_BINS_DEF = 360;

    localparam logic [DIST_W-1:0] NO_GROUND   = 16'd0;
    localparam logic [DIST_W-1:0] NO_OBSTACLE = 16'd63936;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_ROAD    = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_OBJECT  = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_WALL    = 3'd3;

    typedef struct packed {
        logic               kind;
        logic [CLASS_W-1:0] cell_class;
        logic [BIN_W-1:0]   angle_bin;
        logic [DIST_W-1:0]  distance;
    } cell_beat_t;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_index;
        logic [DIST_W-1:0] ground_reach;
        logic [DIST_W-1:0] obstacle_reach;
        logic [DIST_W-1:0] free_reach;
    } bin_result_t;

    typedef struct packed {
        logic [DIST_W-1:0] ground;
        logic [DIST_W-1:0] obstacle;
    } bin_entry_t;

    typedef struct packed {
        logic wr_en;
        logic res_valid;
    } upd_ctl_t;

    localparam bin_entry_t ENTRY_INIT = '{ground: NO_GROUND, obstacle: NO_OBSTACLE};

endpackage

// File: design/pfsb_bin_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsb_bin_mem
// Bin store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfsb_bin_mem #(
    parameter int DEPTH = pfsb_pkg::NUM_BINS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  pfsb_pkg::bin_entry_t wdata,
    input  logic [IDX_W-1:0]     raddr,
    output pfsb_pkg::bin_entry_t rdata
);
    import pfsb_pkg::*;

    bin_entry_t mem [DEPTH];
    bin_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pfsb_clear_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsb_clear_seq
// Post-reset sweep that writes the initial entry into every bin.
// ----------------------------------------------------------------------------
module pfsb_clear_seq #(
    parameter int DEPTH = pfsb_pkg::NUM_BINS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    output logic             busy,
    output logic [IDX_W-1:0] addr
);
    import pfsb_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy = busy_reg;
    assign addr = cnt_reg;

endmodule

// File: design/pfsb_bin_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsb_bin_update
// Per-beat bin logic: raise ground, lower obstacle, or read and clear.
// ----------------------------------------------------------------------------
module pfsb_bin_update (
    input  pfsb_pkg::cell_beat_t  item,
    input  logic                  in_range,
    input  pfsb_pkg::bin_entry_t  stored,
    output pfsb_pkg::upd_ctl_t    ctl,
    output pfsb_pkg::bin_entry_t  new_entry,
    output pfsb_pkg::bin_result_t res
);
    import pfsb_pkg::*;

    bin_entry_t seen;
    logic       is_obstacle;

    assign is_obstacle = (item.cell_class == CLS_OBJECT) ||
                         (item.cell_class == CLS_UNKNOWN) ||
                         (item.cell_class == CLS_WALL);

    always_comb
    begin
        seen          = in_range ? stored : ENTRY_INIT;
        new_entry     = stored;
        ctl.wr_en     = in_range;
        ctl.res_valid = (item.kind == KIND_READ);

        if (item.kind == KIND_READ)
        begin
            new_entry = ENTRY_INIT;
        end
        else if (item.cell_class == CLS_ROAD)
        begin
            if (item.distance > stored.ground)
            begin
                new_entry.ground = item.distance;
            end
        end
        else if (is_obstacle)
        begin
            if (item.distance < stored.obstacle)
            begin
                new_entry.obstacle = item.distance;
            end
        end

        res.bin_index      = item.angle_bin;
        res.ground_reach   = seen.ground;
        res.obstacle_reach = seen.obstacle;
        res.free_reach     = (seen.ground == NO_GROUND || seen.ground > seen.obstacle)
                             ? seen.obstacle : seen.ground;
    end

endmodule

// File: design/polar_free_space_bins.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_free_space_bins
// Polar free-space profile built from classified lidar cells, one beat a cycle.
//
//   channel   ports                 handshake
//   command   start, cmd            accepted when start && !busy
//   result    done, result          one-cycle strobe, no backpressure
//
// One beat per cycle while busy is low; each read result is registered.
// The read-modify-write loop runs through the bin memory read register, with
// the previous write forwarded when consecutive beats hit the same bin.
// After reset busy stays high while every bin is cleared. The receiver cannot
// stall, so only the post-reset clear holds the command side.
// ----------------------------------------------------------------------------
module polar_free_space_bins #(
    parameter int NUM_BINS = pfsb_pkg::NUM_BINS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  pfsb_pkg::cell_beat_t  cmd,
    output logic                  busy,
    output logic                  done,
    output pfsb_pkg::bin_result_t result
);
    import pfsb_pkg::*;

    localparam int IDX_W = $clog2(NUM_BINS);

    logic             accept;
    logic             cmd_in_range;
    logic [IDX_W-1:0] raddr;

    logic             s1_valid_reg;
    cell_beat_t       s1_cmd_reg;
    logic             s1_rng_reg;
    logic [IDX_W-1:0] s1_addr;

    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_addr_reg;
    bin_entry_t       fwd_entry_reg;

    logic             clr_busy;
    logic [IDX_W-1:0] clr_addr;

    bin_entry_t       rdata;
    bin_entry_t       stored;
    upd_ctl_t         ctl;
    bin_entry_t       new_entry;
    bin_result_t      res;
    logic             upd_we;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    bin_entry_t       mem_wdata;

    logic             done_reg;
    bin_result_t      result_reg;

    assign busy         = clr_busy;
    assign accept       = start && !clr_busy;
    assign cmd_in_range = 32'(cmd.angle_bin) < NUM_BINS;
    assign raddr        = cmd_in_range ? IDX_W'(cmd.angle_bin) : '0;
    assign s1_addr      = IDX_W'(s1_cmd_reg.angle_bin);

    pfsb_clear_seq #(
        .DEPTH (NUM_BINS),
        .IDX_W (IDX_W)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    pfsb_bin_mem #(
        .DEPTH (NUM_BINS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // forward the last write when it hit the bin just read
    assign stored = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_entry_reg : rdata;

    pfsb_bin_update u_update (
        .item      (s1_cmd_reg),
        .in_range  (s1_rng_reg),
        .stored    (stored),
        .ctl       (ctl),
        .new_entry (new_entry),
        .res       (res)
    );

    assign upd_we    = s1_valid_reg && ctl.wr_en;
    assign mem_we    = clr_busy || upd_we;
    assign mem_waddr = clr_busy ? clr_addr : s1_addr;
    assign mem_wdata = clr_busy ? ENTRY_INIT : new_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= upd_we;
            done_reg      <= s1_valid_reg && ctl.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
            s1_rng_reg <= cmd_in_range;
        end
        fwd_addr_reg  <= s1_addr;
        fwd_entry_reg <= new_entry;
        result_reg    <= res;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
